// ===== hdl/sal_pkg.sv =====
`default_nettype none

package sal_pkg;

  // Default atlas edge length in columns and rows.
  localparam int ATLAS_SIZE_DEF = 256;

  // Payload field widths.
  localparam int BLK_W = 9;
  localparam int POS_W = 8;

  // Beat widths: fields packed from bit 0, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Request kinds carried on in_tuser.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

endpackage : sal_pkg

`default_nettype wire

// ===== hdl/sal_ram.sv =====
`default_nettype none

// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module sal_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : sal_ram

`default_nettype wire

// ===== hdl/skyline_atlas_allocator.sv =====
`default_nettype none

// Channel | Ports     | Direction | tdata (low bit up)                  | tuser
// in      | in_t*     | slave     | block_width[8:0], block_height[17:9] | operation
// out     | out_t*    | master    | pos_x[7:0], pos_y[15:8]              | fits
//
// A clear request writes zero to every column of the height memory. An allocate
// request makes one forward pass over the height memory, one backward pass, and a
// write-back of the covered columns; the height memory has a single read port. A
// rejected request goes straight to its result. After reset the block clears the
// height memory and holds in_tready low meanwhile. One request is worked on at a
// time; the next beat is taken as soon as the result sits in the output register,
// even if the downstream side stalls it there.

module skyline_atlas_allocator #(
  parameter int ATLAS_SIZE = sal_pkg::ATLAS_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // block_width [8:0], block_height [17:9], zero padding above
  input  wire logic [sal_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation [0]
  input  wire logic [0:0]                     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // pos_x [7:0], pos_y [15:8]
  output logic      [sal_pkg::OUT_DATA_W-1:0] out_tdata,
  // fits [0]
  output logic      [0:0]                     out_tuser
);

  import sal_pkg::*;

  // Address width for ATLAS_SIZE columns, and height width able to hold ATLAS_SIZE.
  localparam int AW = (ATLAS_SIZE > 1) ? $clog2(ATLAS_SIZE) : 1;
  localparam int HW = $clog2(ATLAS_SIZE + 1);
  // Width that holds both a request field and a height, plus a sum bit.
  localparam int CW = (HW > BLK_W) ? HW : BLK_W;
  localparam int SW = CW + 1;

  localparam logic [AW-1:0] LAST_COL = AW'(ATLAS_SIZE - 1);
  localparam logic [HW-1:0] SIZE_H   = HW'(ATLAS_SIZE);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_FWD  = 3'd2;
  localparam logic [2:0] ST_BWD  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    ai_r, ai_nxt;        // issue / write address
  logic             iss_r, iss_nxt;      // read data of pa_r is available
  logic [AW-1:0]    pa_r, pa_nxt;        // column whose data is returning
  logic [AW-1:0]    ph_r, ph_nxt;        // pa_r modulo the block width
  logic [AW-1:0]    cnt_r, cnt_nxt;      // write-back counter
  logic [HW-1:0]    run_r, run_nxt;      // running prefix or suffix maximum
  logic [HW-1:0]    best_r, best_nxt;    // lowest window maximum so far
  logic [AW-1:0]    bx_r, bx_nxt;        // start column of that window
  logic [HW-1:0]    nh_r, nh_nxt;        // new height for covered columns
  logic [AW-1:0]    w_r, w_nxt;
  logic [BLK_W-1:0] h_r, h_nxt;
  logic             clr_rsp_r, clr_rsp_nxt;
  logic             res_fits_r, res_fits_nxt;
  logic [POS_W-1:0] res_x_r, res_x_nxt;
  logic [POS_W-1:0] res_y_r, res_y_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_fits_r, out_fits_nxt;
  logic [POS_W-1:0] out_x_r, out_x_nxt;
  logic [POS_W-1:0] out_y_r, out_y_nxt;

  // Height memory and prefix-maximum memory.
  logic          h_we;
  logic [AW-1:0] h_waddr;
  logic [HW-1:0] h_wdata;
  logic [AW-1:0] h_raddr;
  logic [HW-1:0] h_rdata;
  logic          p_we;
  logic [AW-1:0] p_raddr;
  logic [HW-1:0] p_rdata;

  sal_ram #(.DEPTH(ATLAS_SIZE), .AW(AW), .DW(HW)) u_height_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sal_ram #(.DEPTH(ATLAS_SIZE), .AW(AW), .DW(HW)) u_prefix_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (pa_r),
    .wdata (run_nxt),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // Request fields.
  logic             in_op;
  logic [BLK_W-1:0] in_w;
  logic [BLK_W-1:0] in_h;
  logic             in_fire;
  logic             in_reject;

  assign in_op   = in_tuser[0];
  assign in_w    = in_tdata[BLK_W-1:0];
  assign in_h    = in_tdata[2*BLK_W-1:BLK_W];
  assign in_fire = in_tvalid && in_tready;
  assign in_reject = (in_w == '0) || (in_h == '0) || (CW'(in_w) >= CW'(ATLAS_SIZE));

  assign in_tready = (state_r == ST_IDLE);

  // Datapath terms of the two scan passes.
  logic          blk_first;   // first column of a block (forward pass)
  logic          blk_end;     // last column of a block or of the atlas
  logic [HW-1:0] run_max;
  logic [HW-1:0] scan_val;
  logic [HW-1:0] win_max;
  logic          in_window;
  logic [SW-1:0] top_sum;
  logic          out_free;

  assign blk_first = (ph_r == '0);
  assign blk_end   = (ph_r == w_r - 1'b1) || (pa_r == LAST_COL);
  assign run_max   = (h_rdata > run_r) ? h_rdata : run_r;
  assign win_max   = (scan_val > p_rdata) ? scan_val : p_rdata;
  // Only starts with start + width below the atlas size are tried.
  assign in_window = ((AW+1)'(pa_r) + (AW+1)'(w_r)) < (AW+1)'(ATLAS_SIZE);
  assign top_sum   = SW'(best_r) + SW'(h_r);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    if (state_r == ST_FWD) begin
      scan_val = blk_first ? h_rdata : run_max;
    end else begin
      scan_val = blk_end ? h_rdata : run_max;
    end
  end

  // Memory port control.
  always_comb begin
    h_we    = (state_r == ST_CLR) || (state_r == ST_WB);
    h_waddr = ai_r;
    h_wdata = (state_r == ST_WB) ? nh_r : '0;
    h_raddr = ai_r;
    p_we    = (state_r == ST_FWD) && iss_r;
    p_raddr = AW'((AW+1)'(ai_r) + (AW+1)'(w_r) - 1'b1);
  end

  always_comb begin
    state_nxt    = state_r;
    ai_nxt       = ai_r;
    iss_nxt      = iss_r;
    pa_nxt       = pa_r;
    ph_nxt       = ph_r;
    cnt_nxt      = cnt_r;
    run_nxt      = run_r;
    best_nxt     = best_r;
    bx_nxt       = bx_r;
    nh_nxt       = nh_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    clr_rsp_nxt  = clr_rsp_r;
    res_fits_nxt = res_fits_r;
    res_x_nxt    = res_x_r;
    res_y_nxt    = res_y_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ai_nxt    = '0;
          iss_nxt   = 1'b0;
          ph_nxt    = '0;
          res_x_nxt = '0;
          res_y_nxt = '0;
          w_nxt     = AW'(in_w);
          h_nxt     = in_h;
          if (in_op == OP_CLEAR) begin
            clr_rsp_nxt = 1'b1;
            state_nxt   = ST_CLR;
          end else if (in_reject) begin
            res_fits_nxt = 1'b0;
            state_nxt    = ST_FIN;
          end else begin
            state_nxt = ST_FWD;
          end
        end
      end

      ST_CLR: begin
        if (ai_r == LAST_COL) begin
          res_fits_nxt = 1'b1;
          state_nxt    = clr_rsp_r ? ST_FIN : ST_IDLE;
        end else begin
          ai_nxt = ai_r + 1'b1;
        end
      end

      ST_FWD: begin
        // Issue the next read while the previous one is folded into the prefix.
        iss_nxt = 1'b1;
        pa_nxt  = ai_r;
        if (ai_r != LAST_COL) begin
          ai_nxt = ai_r + 1'b1;
        end
        if (iss_r) begin
          run_nxt = scan_val;
          if (pa_r == LAST_COL) begin
            // ph_r keeps the phase of the last column for the backward pass.
            ai_nxt    = LAST_COL;
            iss_nxt   = 1'b0;
            best_nxt  = SIZE_H;
            bx_nxt    = '0;
            state_nxt = ST_BWD;
          end else begin
            ph_nxt = (ph_r == w_r - 1'b1) ? '0 : ph_r + 1'b1;
          end
        end
      end

      ST_BWD: begin
        iss_nxt = 1'b1;
        pa_nxt  = ai_r;
        if (ai_r != '0) begin
          ai_nxt = ai_r - 1'b1;
        end
        if (iss_r) begin
          run_nxt = scan_val;
          // Scanning downwards, a tie moves the winner to the lower start.
          if (in_window && (win_max <= best_r)) begin
            best_nxt = win_max;
            bx_nxt   = pa_r;
          end
          ph_nxt = (ph_r == '0) ? w_r - 1'b1 : ph_r - 1'b1;
          if (pa_r == '0) begin
            state_nxt = ST_CHK;
          end
        end
      end

      ST_CHK: begin
        if (top_sum > SW'(ATLAS_SIZE)) begin
          res_fits_nxt = 1'b0;
          state_nxt    = ST_FIN;
        end else begin
          nh_nxt       = HW'(top_sum);
          ai_nxt       = bx_r;
          cnt_nxt      = '0;
          res_fits_nxt = 1'b1;
          res_x_nxt    = POS_W'(bx_r);
          res_y_nxt    = POS_W'(best_r);
          state_nxt    = ST_WB;
        end
      end

      ST_WB: begin
        ai_nxt  = ai_r + 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == w_r - 1'b1) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_fits_nxt  = out_fits_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    if ((state_r == ST_FIN) && out_free) begin
      out_valid_nxt = 1'b1;
      out_fits_nxt  = res_fits_r;
      out_x_nxt     = res_x_r;
      out_y_nxt     = res_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Reset starts a silent clearing pass over the height memory.
      state_r     <= ST_CLR;
      ai_r        <= '0;
      iss_r       <= 1'b0;
      clr_rsp_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ai_r        <= ai_nxt;
      iss_r       <= iss_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r       <= pa_nxt;
    ph_r       <= ph_nxt;
    cnt_r      <= cnt_nxt;
    run_r      <= run_nxt;
    best_r     <= best_nxt;
    bx_r       <= bx_nxt;
    nh_r       <= nh_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    res_fits_r <= res_fits_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    out_fits_r <= out_fits_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_y_r, out_x_r};
  assign out_tuser[0] = out_fits_r;

  // An accepted beat always leaves the idle state.
  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // The block phase always stays below the block width during the scans.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FWD) || (state_r == ST_BWD)) |-> (ph_r < w_r))
    else $error("block phase out of range");

  // A written height never exceeds the atlas size.
  a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> ((nh_r <= SIZE_H) && (nh_r != '0)))
    else $error("write-back height out of range");

  // Write-back stays inside the atlas.
  a_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (ai_r <= LAST_COL))
    else $error("write-back beyond last column");

  // A placement whose top leaves room for the height is written back.
  a_fit_check: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CHK) && (top_sum <= SW'(ATLAS_SIZE))) |=> (state_r == ST_WB))
    else $error("fitting rectangle not written back");

endmodule : skyline_atlas_allocator

`default_nettype wire

// ===== test/skyline_atlas_allocator_test.sv =====
`timescale 1ns / 1ps

module skyline_atlas_allocator_test;
  import sal_pkg::*;

  // The atlas edge length that both the block and the height model use.
  localparam int ATLAS = ATLAS_SIZE_DEF;

  // Half of the 20 ns clock period.
  localparam int HALF_PERIOD = 10;

  // The final drain covers one full allocation and a little slack, so that a
  // stray beat coming after the last expected one is still caught.
  localparam int DRAIN_CYCLES = 3 * ATLAS + 300;

  // Only the first few mismatches are printed. All of them are counted.
  localparam int PRINT_LIMIT = 40;

  // One result beat: the fits flag followed by the position of the rectangle.
  typedef struct packed {
    logic             fits;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } placement_t;

  // One row of the directed table. Where known is set, the row carries its
  // expected result. Otherwise the height model decides what the result is.
  typedef struct packed {
    logic             op;
    logic [BLK_W-1:0] width;
    logic [BLK_W-1:0] height;
    logic             known;
    placement_t       want;
  } directed_row_t;

  localparam placement_t NO_FIT    = '{1'b0, 8'd0, 8'd0};
  localparam placement_t AT_ORIGIN = '{1'b1, 8'd0, 8'd0};

  localparam int N_DIRECTED = 25;

  // The directed table walks the edges of the atlas. It covers zero sizes,
  // widths of the full atlas and beyond, heights that can never fit, and clears
  // that carry junk in the size fields. It also places rectangles in the last
  // column that can be tried and in the topmost row.
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_ALLOC, 9'd1,   9'd1,   1'b1, AT_ORIGIN},
    '{OP_ALLOC, 9'd0,   9'd5,   1'b1, NO_FIT},
    '{OP_ALLOC, 9'd5,   9'd0,   1'b1, NO_FIT},
    '{OP_ALLOC, 9'd256, 9'd1,   1'b1, NO_FIT},
    '{OP_ALLOC, 9'd511, 9'd511, 1'b1, NO_FIT},
    '{OP_ALLOC, 9'd255, 9'd1,   1'b0, NO_FIT},
    '{OP_ALLOC, 9'd1,   9'd256, 1'b0, NO_FIT},
    '{OP_CLEAR, 9'd0,   9'd0,   1'b1, AT_ORIGIN},
    '{OP_ALLOC, 9'd1,   9'd256, 1'b1, AT_ORIGIN},
    '{OP_ALLOC, 9'd1,   9'd1,   1'b0, NO_FIT},
    '{OP_ALLOC, 9'd100, 9'd257, 1'b1, NO_FIT},
    '{OP_CLEAR, 9'd511, 9'd511, 1'b1, AT_ORIGIN},
    '{OP_ALLOC, 9'd255, 9'd255, 1'b1, AT_ORIGIN},
    '{OP_ALLOC, 9'd1,   9'd1,   1'b0, NO_FIT},
    '{OP_ALLOC, 9'd1,   9'd2,   1'b0, NO_FIT},
    '{OP_CLEAR, 9'd0,   9'd0,   1'b1, AT_ORIGIN},
    '{OP_ALLOC, 9'd254, 9'd256, 1'b1, AT_ORIGIN},
    '{OP_ALLOC, 9'd1,   9'd1,   1'b0, NO_FIT},
    '{OP_ALLOC, 9'd1,   9'd1,   1'b0, NO_FIT},
    '{OP_CLEAR, 9'd0,   9'd0,   1'b1, AT_ORIGIN},
    '{OP_ALLOC, 9'd128, 9'd128, 1'b0, NO_FIT},
    '{OP_ALLOC, 9'd128, 9'd128, 1'b0, NO_FIT},
    '{OP_ALLOC, 9'd127, 9'd64,  1'b0, NO_FIT},
    '{OP_ALLOC, 9'd1,   9'd511, 1'b1, NO_FIT},
    '{OP_ALLOC, 9'd3,   9'd7,   1'b0, NO_FIT}
  };

  // The random part runs in four phases of idling, each of this many beats.
  localparam int PHASE_ITEMS = 293;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  // This is the testbench's own copy of the skyline, one fill height per column.
  logic [BLK_W-1:0] fill_height [ATLAS];

  // Results still owed by the block, oldest first.
  placement_t placements_due [$];

  int mismatch_count;
  int results_seen;

  // The current idling rates, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;

  skyline_atlas_allocator #(
    .ATLAS_SIZE(ATLAS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // block_width [8:0], block_height [17:9]
    .in_tuser  (in_tuser),   // operation [0]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // pos_x [7:0], pos_y [15:8]
    .out_tuser (out_tuser)   // fits [0]
  );

  always #(HALF_PERIOD) clk = ~clk;

  // This function works out where one request lands and updates the skyline.
  // Every start column whose window leaves at least one column to its right is
  // scanned. A start stays a candidate only while every column under it lies
  // below the best top found so far, so the first start that reaches the
  // lowest top is the one that wins.
  function automatic placement_t place_rect(logic op, logic [BLK_W-1:0] w,
                                            logic [BLK_W-1:0] h);
    placement_t res;
    int best;
    int bx;
    int top;
    int s;
    int k;
    bit found;
    bit ok;
    res = NO_FIT;
    if (op == OP_CLEAR) begin
      foreach (fill_height[i]) fill_height[i] = '0;
      res.fits = 1'b1;
      return res;
    end
    if (w == 0 || h == 0 || w >= ATLAS) return res;
    best  = ATLAS;
    bx    = 0;
    found = 1'b0;
    for (s = 0; s + w < ATLAS; s++) begin
      top = 0;
      ok  = 1'b1;
      for (k = 0; k < w; k++) begin
        if (fill_height[s + k] >= best) begin
          ok = 1'b0;
          break;
        end
        if (fill_height[s + k] > top) top = fill_height[s + k];
      end
      if (ok) begin
        best  = top;
        bx    = s;
        found = 1'b1;
      end
    end
    // A rectangle that would rise above the top edge is refused, and the
    // skyline is left as it was.
    if (!found || best + h > ATLAS) return res;
    for (k = 0; k < w; k++) fill_height[bx + k] = BLK_W'(best + h);
    res.fits  = 1'b1;
    res.pos_x = POS_W'(bx);
    res.pos_y = POS_W'(best);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("tb: result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // This task offers one request beat after a random idle spell and waits for
  // it to be taken. The model advances only once the beat has been accepted,
  // so the queue of owed results stays in the block's own order. A row with a
  // known result still runs through the model to keep the skyline in step.
  task automatic send_request(logic op, logic [BLK_W-1:0] w, logic [BLK_W-1:0] h,
                              bit known, placement_t known_want);
    placement_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - 2 * BLK_W){1'b0}}, h, w};
    do @(posedge clk); while (!in_tready);
    pred = place_rect(op, w, h);
    placements_due.push_back(known ? known_want : pred);
  endtask

  // The receiving side. A result beat is taken at any edge where valid and
  // ready are both high, and it is checked field by field against the oldest
  // owed result. Ready is redrawn every cycle at the current stall rate.
  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (placements_due.size() == 0) begin
        if (mismatch_count < PRINT_LIMIT)
          $display("tb: result %0d arrived with nothing outstanding", results_seen);
        mismatch_count++;
      end else begin
        want = placements_due.pop_front();
        if (out_tuser[0] !== want.fits)
          report_mismatch("fits", out_tuser[0], want.fits);
        if (out_tdata[POS_W-1:0] !== want.pos_x)
          report_mismatch("pos_x", out_tdata[POS_W-1:0], want.pos_x);
        if (out_tdata[2*POS_W-1:POS_W] !== want.pos_y)
          report_mismatch("pos_y", out_tdata[2*POS_W-1:POS_W], want.pos_y);
      end
      results_seen++;
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The stimulus. The directed table comes first, with no idling, and is
  // followed by four random phases with different idling rates. Most random
  // requests are small allocations, so the skyline fills up and the scan has
  // real work to do. Now and then a clear resets it, and a few requests carry
  // oversized or zero fields.
  initial begin
    int phase;
    int i;
    int sel;
    logic             op;
    logic [BLK_W-1:0] w;
    logic [BLK_W-1:0] h;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (fill_height[j]) fill_height[j] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++)
      send_request(DIRECTED[i].op, DIRECTED[i].width, DIRECTED[i].height,
                   DIRECTED[i].known, DIRECTED[i].want);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 3) begin
          // A clear ignores the size fields, so they carry random junk.
          op = OP_CLEAR;
          w  = BLK_W'($urandom_range(511));
          h  = BLK_W'($urandom_range(511));
        end else begin
          op  = OP_ALLOC;
          sel = $urandom_range(99);
          if (sel < 72)      w = BLK_W'($urandom_range(32, 1));
          else if (sel < 90) w = BLK_W'($urandom_range(255, 33));
          else if (sel < 95) w = BLK_W'($urandom_range(511, 256));
          else               w = '0;
          sel = $urandom_range(99);
          if (sel < 75)      h = BLK_W'($urandom_range(48, 1));
          else if (sel < 92) h = BLK_W'($urandom_range(256, 49));
          else if (sel < 97) h = BLK_W'($urandom_range(511, 257));
          else               h = '0;
        end
        send_request(op, w, h, 1'b0, NO_FIT);
      end
    end
    in_tvalid <= 1'b0;

    while (placements_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // The watchdog. Its limit leaves several times the slowest correct run with every
  // stall in place.
  initial begin
    #150_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
